### rtl/mmsb_pkg.sv
// Shared types and constants for the multichannel moving-sum buffer.
// Depends on nothing; the top level refers to it by scoped names.
package mmsb_pkg;

	localparam int CMD_W    = 2;
	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 18;
	localparam int AVG_W    = 12;

	// Value of every sample after reset (mid-scale of the converter).
	localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 12'd2048;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE    = 2'd0,
		CMD_ADVANCE  = 2'd1,
		CMD_SNAPSHOT = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_t;

endpackage

### rtl/multichannel_moving_sum_buffer_top.sv
// Multichannel moving-sum buffer: per-channel sample rings and window sums in
// two synchronous memories, updated by read-modify-write. Depends on mmsb_pkg.
//
// One request is taken every clock cycle while req_stall is low, and its result
// passes the memory read, the read-modify-write with forwarding and the divide by
// reciprocal multiply before it leaves. The rate is set by the sample and sum
// memories: each request does two sample reads and one sum read and at most one
// write-back to each, and the most recent write is forwarded into the following
// request. After reset the block runs a clearing pass that loads every sample
// with 2048 and every sum with 2048 * WINDOW_DEPTH; req_stall stays high until
// it ends. A request for a channel at or above CHANNELS writes nothing and
// returns zeros, but advance and snapshot still move the shared positions.
module multichannel_moving_sum_buffer_top #(
	parameter int CHANNELS     = 16,
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [mmsb_pkg::CMD_W-1:0]      cmd,
	input  logic [mmsb_pkg::CHAN_W-1:0]     channel,
	input  logic [mmsb_pkg::SAMPLE_W-1:0]   sample,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [mmsb_pkg::SAMPLE_W-1:0]   latest,
	output logic [mmsb_pkg::SUM_W-1:0]      window_sum,
	output logic [mmsb_pkg::AVG_W-1:0]      window_average
);

	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW     = $clog2(WINDOW_DEPTH);
	localparam int AW     = CW + SW;
	localparam int SUM_W  = mmsb_pkg::SUM_W;
	localparam int SMP_W  = mmsb_pkg::SAMPLE_W;
	localparam int DIV_SH = SUM_W + SW;
	localparam int PROD_W = 2 * SUM_W + 1;
	// floor(x / WINDOW_DEPTH) == (x * RECIP) >> DIV_SH for every 18-bit x
	localparam logic [SUM_W:0] RECIP =
		(SUM_W+1)'(((64'd1 << DIV_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
	localparam logic [SUM_W-1:0] SUM_RESET =
		SUM_W'(64'(mmsb_pkg::SAMPLE_RESET) * 64'(WINDOW_DEPTH));
	localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_DEPTH - 1);

	// Storage
	logic [SMP_W-1:0] smem [2**AW];
	logic [SUM_W-1:0] sum_mem [2**CW];

	// Clearing pass and shared positions
	logic [AW:0]      clr_q;
	logic             clr_done;
	logic [SW-1:0]    wp_q, rp_q, wp_next, rp_next;

	// Request decode
	mmsb_pkg::cmd_t   cmd_in;
	logic [CW+mmsb_pkg::CHAN_W-1:0] ch_wide;
	logic [CW-1:0]    ch_idx;
	logic             ch_ok;
	logic             acc;

	// Stage 1: memory data available
	logic             s1_v_q;
	mmsb_pkg::cmd_t   s1_cmd;
	logic             s1_ok;
	logic [CW-1:0]    s1_ch;
	logic [AW-1:0]    s1_wr_addr, s1_rd_addr;
	logic [SMP_W-1:0] s1_smp, old_s1, lat_s1;
	logic [SUM_W-1:0] sum_s1;

	// Last write, forwarded into the following request
	logic             lw_v_q;
	logic [AW-1:0]    lw_addr_q;
	logic [CW-1:0]    lw_ch_q;
	logic [SMP_W-1:0] lw_smp_q;
	logic [SUM_W-1:0] lw_sum_q;

	logic             s1_wr;
	logic [SMP_W-1:0] old_fw, lat_fw;
	logic [SUM_W-1:0] sum_fw, sum_new;

	// Stage 2 and output stage
	logic             s2_v_q;
	logic [SMP_W-1:0] s2_latest;
	logic [SUM_W-1:0] s2_sum;
	logic [PROD_W-1:0] prod;
	logic             s3_v_q;
	logic [SMP_W-1:0] latest_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [mmsb_pkg::AVG_W-1:0] avg_s3;

	logic             s3_free, s2_free, s1_free, s1_go, s2_go;

	assign clr_done = clr_q[AW];

	// Backpressure chain from the output register back to the request side
	assign s3_free   = !s3_v_q || !res_stall;
	assign s2_go     = s2_v_q && s3_free;
	assign s2_free   = !s2_v_q || s3_free;
	assign s1_go     = s1_v_q && s2_free;
	assign s1_free   = !s1_v_q || s2_free;
	assign req_stall = !clr_done || !s1_free;
	assign acc       = req_valid && !req_stall;

	assign cmd_in  = mmsb_pkg::cmd_t'(cmd);
	assign ch_wide = {{CW{1'b0}}, channel};
	assign ch_idx  = ch_wide[CW-1:0];
	assign ch_ok   = 7'(channel) < 7'(CHANNELS);

	always_comb begin
		wp_next = wp_q;
		rp_next = rp_q;
		unique case (cmd_in)
			mmsb_pkg::CMD_ADVANCE:  wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + SW'(1);
			mmsb_pkg::CMD_SNAPSHOT: rp_next = wp_q;
			mmsb_pkg::CMD_WRITE,
			mmsb_pkg::CMD_QUERY:    ;
			default:                ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
		end else begin
			if (!clr_done) begin
				clr_q <= clr_q + (AW+1)'(1);
			end
			if (acc) begin
				wp_q <= wp_next;
				rp_q <= rp_next;
			end
		end
	end

	// Memories: clearing pass or write-back, and the reads of an accepted request
	always_ff @(posedge clk) begin
		if (!clr_done) begin
			smem[clr_q[AW-1:0]] <= mmsb_pkg::SAMPLE_RESET;
			if (clr_q[SW-1:0] == '0) begin
				sum_mem[clr_q[AW-1:SW]] <= SUM_RESET;
			end
		end else if (s1_go && s1_wr) begin
			smem[s1_wr_addr] <= s1_smp;
			sum_mem[s1_ch]   <= sum_new;
		end
		if (acc) begin
			old_s1 <= smem[{ch_idx, wp_q}];
			lat_s1 <= smem[{ch_idx, rp_next}];
			sum_s1 <= sum_mem[ch_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_cmd     <= cmd_in;
			s1_ok      <= ch_ok;
			s1_ch      <= ch_idx;
			s1_wr_addr <= {ch_idx, wp_q};
			s1_rd_addr <= {ch_idx, rp_next};
			s1_smp     <= sample;
		end
	end

	// Read-modify-write with forwarding of the last write
	always_comb begin
		s1_wr  = (s1_cmd == mmsb_pkg::CMD_WRITE) && s1_ok;
		old_fw = (lw_v_q && lw_addr_q == s1_wr_addr) ? lw_smp_q : old_s1;
		sum_fw = (lw_v_q && lw_ch_q == s1_ch) ? lw_sum_q : sum_s1;
		sum_new = sum_fw - SUM_W'(old_fw) + SUM_W'(s1_smp);
		// the read slot sees this request's own write
		if (s1_wr && s1_rd_addr == s1_wr_addr) begin
			lat_fw = s1_smp;
		end else if (lw_v_q && lw_addr_q == s1_rd_addr) begin
			lat_fw = lw_smp_q;
		end else begin
			lat_fw = lat_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (s1_go && s1_wr) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_wr) begin
			lw_addr_q <= s1_wr_addr;
			lw_ch_q   <= s1_ch;
			lw_smp_q  <= s1_smp;
			lw_sum_q  <= sum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
		end else begin
			if (s1_go) begin
				s2_v_q <= 1'b1;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				s3_v_q <= 1'b1;
			end else if (s3_free) begin
				s3_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			// drop results of an out-of-range channel to zero
			s2_latest <= s1_ok ? lat_fw : '0;
			s2_sum    <= s1_ok ? (s1_wr ? sum_new : sum_fw) : '0;
		end
	end

	assign prod = PROD_W'(s2_sum) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (s2_go) begin
			latest_s3 <= s2_latest;
			sum_s3    <= s2_sum;
			avg_s3    <= prod[DIV_SH +: mmsb_pkg::AVG_W];
		end
	end

	assign res_valid      = s3_v_q;
	assign latest         = latest_s3;
	assign window_sum     = sum_s3;
	assign window_average = avg_s3;

endmodule

### dv/testbench.sv
// Self-checking testbench for multichannel_moving_sum_buffer_top: directed and random
// requests, an in-bench model of the sample rings and window sums, in-order result checks.
// Depends on mmsb_pkg and the top level in rtl/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS     = 16;
	localparam int WINDOW_DEPTH = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [mmsb_pkg::SAMPLE_W-1:0] latest;
		logic [mmsb_pkg::SUM_W-1:0]    sum;
		logic [mmsb_pkg::AVG_W-1:0]    avg;
	} window_result_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	logic [mmsb_pkg::CMD_W-1:0]    cmd       = mmsb_pkg::CMD_QUERY;
	logic [mmsb_pkg::CHAN_W-1:0]   channel   = '0;
	logic [mmsb_pkg::SAMPLE_W-1:0] sample    = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [mmsb_pkg::SAMPLE_W-1:0] latest;
	logic [mmsb_pkg::SUM_W-1:0]    window_sum;
	logic [mmsb_pkg::AVG_W-1:0]    window_average;

	// Model state: per-channel rings and sums, shared positions.
	logic [mmsb_pkg::SAMPLE_W-1:0] ring [CHANNELS][WINDOW_DEPTH];
	logic [mmsb_pkg::SUM_W-1:0]    ring_sum [CHANNELS];
	int                            wr_pos;
	int                            rd_pos;

	window_result_t      pending_results [$];
	int                  sent_count;
	int                  checked_count;
	int                  err_count;
	int                  cycles;
	int                  burst_left;
	bit                  sender_idle_on;
	bit                  hold_request;

	multichannel_moving_sum_buffer_top #(
		.CHANNELS     (CHANNELS),
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.cmd            (cmd),
		.channel        (channel),
		.sample         (sample),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.latest         (latest),
		.window_sum     (window_sum),
		.window_average (window_average)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_rings();
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < WINDOW_DEPTH; k++)
				ring[c][k] = mmsb_pkg::SAMPLE_RESET;
			ring_sum[c] = mmsb_pkg::SUM_W'(mmsb_pkg::SAMPLE_RESET * WINDOW_DEPTH);
		end
		wr_pos = 0;
		rd_pos = 0;
	endfunction

	// Apply one request to the model and return the result it causes.
	function automatic window_result_t step_window(mmsb_pkg::cmd_t op,
			logic [mmsb_pkg::CHAN_W-1:0] ch, logic [mmsb_pkg::SAMPLE_W-1:0] smp);
		window_result_t r;
		bit in_range;
		in_range = (int'(ch) < CHANNELS);
		case (op)
			mmsb_pkg::CMD_WRITE: begin
				if (in_range) begin
					ring_sum[ch] = ring_sum[ch] - ring[ch][wr_pos] + smp;
					ring[ch][wr_pos] = smp;
				end
			end
			mmsb_pkg::CMD_ADVANCE: begin
				wr_pos = (wr_pos == WINDOW_DEPTH - 1) ? 0 : wr_pos + 1;
			end
			mmsb_pkg::CMD_SNAPSHOT: begin
				rd_pos = wr_pos;
			end
			default: ;
		endcase
		r = '0;
		if (in_range) begin
			r.latest = ring[ch][rd_pos];
			r.sum    = ring_sum[ch];
			r.avg    = mmsb_pkg::AVG_W'(ring_sum[ch] / WINDOW_DEPTH);
		end
		return r;
	endfunction

	// Drive one request, hold it until taken, then record its expected result.
	task automatic send_req(mmsb_pkg::cmd_t op, logic [mmsb_pkg::CHAN_W-1:0] ch,
			logic [mmsb_pkg::SAMPLE_W-1:0] smp);
		int gap;
		if (sender_idle_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		req_valid <= 1'b1;
		cmd       <= op;
		channel   <= ch;
		sample    <= smp;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		pending_results.push_back(step_window(op, ch, smp));
		sent_count++;
	endtask

	function automatic mmsb_pkg::cmd_t pick_cmd(int write_pct, int adv_pct, int snap_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < write_pct)
			return mmsb_pkg::CMD_WRITE;
		else if (r < write_pct + adv_pct)
			return mmsb_pkg::CMD_ADVANCE;
		else if (r < write_pct + adv_pct + snap_pct)
			return mmsb_pkg::CMD_SNAPSHOT;
		return mmsb_pkg::CMD_QUERY;
	endfunction

	function automatic logic [mmsb_pkg::SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return mmsb_pkg::SAMPLE_W'($urandom);
	endfunction

	task automatic test_reset_values();
		send_req(mmsb_pkg::CMD_QUERY, 4'd0, '0);
		send_req(mmsb_pkg::CMD_QUERY, 4'd15, '1);
	endtask

	task automatic test_write_extremes();
		send_req(mmsb_pkg::CMD_WRITE, 4'd0, 12'h000);
		send_req(mmsb_pkg::CMD_WRITE, 4'd15, 12'hFFF);
		send_req(mmsb_pkg::CMD_WRITE, 4'd5, 12'hAAA);
		send_req(mmsb_pkg::CMD_WRITE, 4'd10, 12'h555);
	endtask

	task automatic test_position_wrap();
		send_req(mmsb_pkg::CMD_SNAPSHOT, 4'd15, '0);
		// step through every slot and back to zero
		for (int k = 0; k < WINDOW_DEPTH; k++)
			send_req(mmsb_pkg::CMD_ADVANCE, mmsb_pkg::CHAN_W'(k), '0);
		send_req(mmsb_pkg::CMD_WRITE, 4'd15, 12'h001);
		send_req(mmsb_pkg::CMD_SNAPSHOT, 4'd15, '0);
		send_req(mmsb_pkg::CMD_QUERY, 4'd15, '0);
	endtask

	task automatic test_back_to_back_writes();
		// same channel twice in a row: exercises the write-back forwarding
		send_req(mmsb_pkg::CMD_WRITE, 4'd7, 12'hFFF);
		send_req(mmsb_pkg::CMD_WRITE, 4'd7, 12'h123);
		send_req(mmsb_pkg::CMD_QUERY, 4'd7, '0);
	endtask

	task automatic test_random_stream(int n);
		logic [mmsb_pkg::CHAN_W-1:0] ch;
		ch = '0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0)
				ch = mmsb_pkg::CHAN_W'($urandom);
			send_req(pick_cmd(60, 15, 12), ch, pick_sample());
		end
	endtask

	task automatic test_hot_channels(int n);
		logic [mmsb_pkg::CHAN_W-1:0] pair [2];
		pair[0] = mmsb_pkg::CHAN_W'($urandom);
		pair[1] = mmsb_pkg::CHAN_W'($urandom);
		for (int i = 0; i < n; i++)
			send_req(pick_cmd(50, 25, 15), pair[$urandom_range(0, 1)], pick_sample());
	endtask

	task automatic test_output_hold(int n);
		sender_idle_on = 1'b0;
		hold_request = 1'b1;
		test_random_stream(n);
		sender_idle_on = 1'b1;
	endtask

	// Receiver back-pressure: changing patterns plus one long hold when asked.
	initial begin
		int mode;
		int mode_left;
		int phase;
		mode = 0;
		mode_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				phase = (phase + 1) % 7;
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= (phase < 3);
					default: res_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Compare every taken result with the oldest expectation.
	initial begin
		window_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: latest %0d sum %0d avg %0d",
						latest, window_sum, window_average);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					checked_count++;
					if (latest !== want.latest) begin
						$error("latest: expected %0d, actual %0d", want.latest, latest);
						err_count++;
					end
					if (window_sum !== want.sum) begin
						$error("window_sum: expected %0d, actual %0d", want.sum, window_sum);
						err_count++;
					end
					if (window_average !== want.avg) begin
						$error("window_average: expected %0d, actual %0d",
							want.avg, window_average);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_results.size());
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		sent_count = 0;
		checked_count = 0;
		err_count = 0;
		burst_left = 0;
		sender_idle_on = 1'b1;
		hold_request = 1'b0;
		clear_rings();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_write_extremes();
		test_position_wrap();
		test_back_to_back_writes();
		test_random_stream(500);
		test_output_hold(150);
		test_hot_channels(200);
		test_random_stream(100);

		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("testbench: %0d requests, %0d results checked; writes, advances with wrap,",
			sent_count, checked_count);
		$display("testbench: snapshots, queries, same-channel bursts and a long output hold");
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
